@@ rtl/erle_pkg.sv @@
// Shared types and constants for the escape-coded run-length block decoder.
package erle_pkg;

    localparam logic [7:0]  ESC_BYTE    = 8'hED;
    localparam int          CFG_IDX_W   = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 8'd1;
    localparam logic [15:0] START_RESET = 16'h4000;
    localparam logic [15:0] SIZE_RESET  = 16'hC000;
    localparam int          QDEPTH      = 3;
    localparam int          QCNT_W      = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE_ESC,
        PH_TWO_ESC,
        PH_HAVE_COUNT
    } t_phase;

    typedef struct packed {
        logic [15:0] dest_address;
        logic [7:0]  fill_value;
        logic [7:0]  run_length;
        logic        finished;
        logic        last_of_input;
    } t_result;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
        logic    done;
    } t_dec_out;

endpackage

@@ rtl/escape_rle_block_decoder.sv @@
// Top level of the escape-coded run-length block decoder with its result queue.
// One compressed byte is taken per clock cycle while o_s_tready is high. Each byte is
// decoded in the cycle it is accepted and its runs land in a three-entry result queue,
// which shows one run per cycle on the master side while i_m_tready is high. The input
// is ready whenever the queue holds at most one run, so with a ready sink a stream of
// one-run bytes flows at one byte per cycle; a lone escape and its literal give two runs.
// Configuration writes reload the decode state from the registers and are always ready.
module escape_rle_block_decoder
    import erle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] code_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_m_tdata,   // [15:0] dest_address, [23:16] fill_value,
                                              // [31:24] run_length
    output logic                 o_m_tuser,   // [0] finished
    output logic                 o_m_tlast,   // last_of_input
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_result           r_q [QDEPTH];
    t_result           n_q [QDEPTH];
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic [QCNT_W-1:0] base;
    logic              accept;
    logic              pop;
    t_dec_out          dec;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_count <= QCNT_W'(1));
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = (r_count != '0);
    assign pop         = o_m_tvalid && i_m_tready;

    erle_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_byte (i_s_tdata),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dec       (dec)
    );

    // shift out the head, append new runs behind what stays
    always_comb begin
        base = r_count - {{(QCNT_W-1){1'b0}}, pop};
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && (i < QDEPTH - 1)) n_q[i] = r_q[(i + 1) % QDEPTH];
            else                         n_q[i] = r_q[i];
            if (dec.valid0 && (base == QCNT_W'(i)))          n_q[i] = dec.res0;
            if (dec.valid1 && (base + 2'd1 == QCNT_W'(i)))   n_q[i] = dec.res1;
        end
        n_count = base + {{(QCNT_W-1){1'b0}}, dec.valid0}
                       + {{(QCNT_W-1){1'b0}}, dec.valid1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_m_tdata = {r_q[0].run_length, r_q[0].fill_value, r_q[0].dest_address};
    assign o_m_tuser = r_q[0].finished;
    assign o_m_tlast = r_q[0].last_of_input;

    a_partner_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (r_count >= QCNT_W'(2)))
        else $error("first run of a pair shown without its partner queued");

    a_empty_run_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[31:24] == 8'd0)) |-> o_m_tuser)
        else $error("zero-length run not marked finished");

    a_done_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && dec.done && !i_cfg_valid) |=> (r_count <= $past(r_count)))
        else $error("run queued after block completed");

endmodule

@@ rtl/erle_decode.sv @@
// Decode state, configuration registers and per-byte run decoding.
module erle_decode
    import erle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_code_byte,
    input  logic                 i_cfg_write,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_dec_out             o_dec
);

    logic [15:0] r_start;
    logic [15:0] r_size;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_count;
    logic [7:0]  n_count;
    logic [15:0] r_addr;
    logic [15:0] n_addr;
    logic [15:0] r_left;
    logic [15:0] n_left;
    logic        r_done;
    logic        n_done;

    logic        blocked;
    logic        step;
    logic [15:0] left_m1;
    logic [15:0] left_m2;
    logic [15:0] addr_p1;
    logic [7:0]  len;
    logic [15:0] left_run;
    logic        valid0;
    logic        valid1;
    t_result     res0;
    t_result     res1;

    assign blocked  = r_done || (r_left == 16'd0);
    assign step     = i_accept && !blocked;
    assign left_m1  = r_left - 16'd1;
    assign left_m2  = r_left - 16'd2;
    assign addr_p1  = r_addr + 16'd1;
    assign len      = ({8'd0, r_count} > r_left) ? r_left[7:0] : r_count;
    assign left_run = r_left - {8'd0, len};

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_code_byte == ESC_BYTE) n_phase = PH_ONE_ESC;
            end
            PH_ONE_ESC: begin
                n_phase = (i_code_byte == ESC_BYTE) ? PH_TWO_ESC : PH_IDLE;
            end
            PH_TWO_ESC: begin
                n_phase = (i_code_byte == 8'd0) ? PH_IDLE : PH_HAVE_COUNT;
            end
            PH_HAVE_COUNT: begin
                n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // results and data state
    always_comb begin
        valid0 = 1'b0;
        valid1 = 1'b0;
        res0   = '{dest_address: r_addr, fill_value: i_code_byte, run_length: 8'd1,
                   finished: 1'b0, last_of_input: 1'b1};
        res1   = '{dest_address: addr_p1, fill_value: i_code_byte, run_length: 8'd1,
                   finished: 1'b0, last_of_input: 1'b1};
        n_count = r_count;
        n_addr  = r_addr;
        n_left  = r_left;
        n_done  = r_done;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_code_byte != ESC_BYTE) begin
                    valid0        = 1'b1;
                    res0.finished = (left_m1 == 16'd0);
                    n_addr        = addr_p1;
                    n_left        = left_m1;
                    n_done        = (left_m1 == 16'd0);
                end
            end
            PH_ONE_ESC: begin
                if (i_code_byte != ESC_BYTE) begin
                    valid0          = 1'b1;
                    res0.fill_value = ESC_BYTE;
                    res0.finished   = (left_m1 == 16'd0);
                    if (left_m1 == 16'd0) begin
                        n_addr = addr_p1;
                        n_left = left_m1;
                        n_done = 1'b1;
                    end else begin
                        valid1             = 1'b1;
                        res0.last_of_input = 1'b0;
                        res1.finished      = (left_m2 == 16'd0);
                        n_addr             = r_addr + 16'd2;
                        n_left             = left_m2;
                        n_done             = (left_m2 == 16'd0);
                    end
                end
            end
            PH_TWO_ESC: begin
                if (i_code_byte == 8'd0) begin
                    valid0          = 1'b1;
                    res0.fill_value = 8'd0;
                    res0.run_length = 8'd0;
                    res0.finished   = 1'b1;
                    n_done          = 1'b1;
                end else begin
                    n_count = i_code_byte;
                end
            end
            PH_HAVE_COUNT: begin
                valid0          = 1'b1;
                res0.run_length = len;
                res0.finished   = (left_run == 16'd0);
                n_addr          = r_addr + {8'd0, len};
                n_left          = left_run;
                n_done          = (left_run == 16'd0);
                n_count         = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_size  <= SIZE_RESET;
            r_phase <= PH_IDLE;
            r_count <= 8'd0;
            r_addr  <= START_RESET;
            r_left  <= SIZE_RESET;
            r_done  <= 1'b0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_START_ADDR: begin
                    r_start <= i_cfg_data;
                    r_phase <= PH_IDLE;
                    r_count <= 8'd0;
                    r_addr  <= i_cfg_data;
                    r_left  <= r_size;
                    r_done  <= 1'b0;
                end
                CFG_BLOCK_SIZE: begin
                    r_size  <= i_cfg_data;
                    r_phase <= PH_IDLE;
                    r_count <= 8'd0;
                    r_addr  <= r_start;
                    r_left  <= i_cfg_data;
                    r_done  <= 1'b0;
                end
                default: ;
            endcase
        end else if (step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_left  <= n_left;
            r_done  <= n_done;
        end
    end

    assign o_dec = '{valid0: step && valid0, valid1: step && valid1,
                     res0: res0, res1: res1, done: blocked};

endmodule

@@ dv/testbench.sv @@
// Self-checking stream testbench for the escape-coded run-length block decoder.
`timescale 1ns / 100ps

module testbench;
    import erle_pkg::*;

    localparam int ITEM_TARGET  = 1950;
    localparam int QUIET_TAIL   = 250;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [31:0]          o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    escape_rle_block_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder shadow state
    logic [15:0] cfg_start = START_RESET;
    logic [15:0] cfg_size  = SIZE_RESET;
    t_phase      dec_phase = PH_IDLE;
    logic [7:0]  held_count = '0;
    logic [15:0] dest_ptr = START_RESET;
    logic [15:0] room_left = SIZE_RESET;
    logic        block_done = 1'b0;

    logic [7:0]  code_backlog[$];
    t_result     expected_runs[$];
    t_result     want_run;

    int  mismatches = 0;
    int  sent_bytes = 0;
    int  live_bytes = 0;
    int  runs_seen = 0;
    int  blocks_done = 0;
    int  settings_used = 0;
    int  reg_writes = 0;
    int  cycle_count = 0;
    int  src_gap = 0;
    int  sink_stall = 0;
    bit  idling_on = 1'b0;
    bit  quiet = 1'b0;

    function automatic void restart_decode();
        dec_phase  = PH_IDLE;
        held_count = '0;
        dest_ptr   = cfg_start;
        room_left  = cfg_size;
        block_done = 1'b0;
    endfunction

    function automatic t_result make_run(input logic [7:0] value, input logic [7:0] len);
        t_result r;
        r.dest_address  = dest_ptr;
        r.fill_value    = value;
        r.run_length    = len;
        dest_ptr        = dest_ptr + {8'd0, len};
        room_left       = room_left - {8'd0, len};
        if (room_left == 16'd0)
            block_done = 1'b1;
        r.finished      = block_done;
        r.last_of_input = 1'b0;
        return r;
    endfunction

    function automatic void decode_code_byte(input logic [7:0] b);
        t_result    res[2];
        int         n;
        logic [7:0] len;
        n = 0;
        if (block_done || room_left == 16'd0)
            return;
        live_bytes++;
        case (dec_phase)
            PH_IDLE: begin
                if (b == ESC_BYTE) begin
                    dec_phase = PH_ONE_ESC;
                end else begin
                    res[0] = make_run(b, 8'd1);
                    n = 1;
                end
            end
            PH_ONE_ESC: begin
                if (b == ESC_BYTE) begin
                    dec_phase = PH_TWO_ESC;
                end else begin
                    dec_phase = PH_IDLE;
                    res[0] = make_run(ESC_BYTE, 8'd1);
                    n = 1;
                    // drop the follower once the block is full
                    if (!block_done) begin
                        res[1] = make_run(b, 8'd1);
                        n = 2;
                    end
                end
            end
            PH_TWO_ESC: begin
                if (b == 8'd0) begin
                    dec_phase  = PH_IDLE;
                    block_done = 1'b1;
                    res[0].dest_address  = dest_ptr;
                    res[0].fill_value    = 8'd0;
                    res[0].run_length    = 8'd0;
                    res[0].finished      = 1'b1;
                    res[0].last_of_input = 1'b0;
                    n = 1;
                end else begin
                    held_count = b;
                    dec_phase  = PH_HAVE_COUNT;
                end
            end
            default: begin
                len = ({8'd0, held_count} > room_left) ? room_left[7:0] : held_count;
                dec_phase  = PH_IDLE;
                held_count = '0;
                res[0] = make_run(b, len);
                n = 1;
            end
        endcase
        if (n > 0)
            res[n-1].last_of_input = 1'b1;
        for (int i = 0; i < n; i++)
            expected_runs.push_back(res[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                sent_bytes++;
                decode_code_byte(i_s_tdata);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (code_backlog.size() > 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= code_backlog.pop_front();
                    if (idling_on && !quiet && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 4);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                runs_seen++;
                if (o_m_tuser)
                    blocks_done++;
                if (expected_runs.size() == 0) begin
                    report_mismatch("unexpected run", o_m_tdata, 32'd0);
                end else begin
                    want_run = expected_runs.pop_front();
                    if (o_m_tdata[15:0] !== want_run.dest_address)
                        report_mismatch("dest_address", 32'(o_m_tdata[15:0]),
                                        32'(want_run.dest_address));
                    if (o_m_tdata[23:16] !== want_run.fill_value)
                        report_mismatch("fill_value", 32'(o_m_tdata[23:16]),
                                        32'(want_run.fill_value));
                    if (o_m_tdata[31:24] !== want_run.run_length)
                        report_mismatch("run_length", 32'(o_m_tdata[31:24]),
                                        32'(want_run.run_length));
                    if (o_m_tuser !== want_run.finished)
                        report_mismatch("finished", 32'(o_m_tuser), 32'(want_run.finished));
                    if (o_m_tlast !== want_run.last_of_input)
                        report_mismatch("last_of_input", 32'(o_m_tlast),
                                        32'(want_run.last_of_input));
                end
            end
            if (idling_on && !quiet && sink_stall == 0 && $urandom_range(0, 5) == 0)
                sink_stall = $urandom_range(1, 4);
            if (sink_stall > 0) begin
                sink_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START_ADDR)
            cfg_start = val;
        else
            cfg_size = val;
        restart_decode();
        reg_writes++;
    endtask

    task automatic wait_for_idle();
        do @(posedge i_clk);
        while (code_backlog.size() != 0 || i_s_tvalid || expected_runs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == ESC_BYTE);
        return b;
    endfunction

    function automatic void queue_lone_esc(input logic [7:0] follower);
        code_backlog.push_back(ESC_BYTE);
        code_backlog.push_back(follower);
    endfunction

    function automatic void queue_run(input logic [7:0] count, input logic [7:0] value);
        code_backlog.push_back(ESC_BYTE);
        code_backlog.push_back(ESC_BYTE);
        code_backlog.push_back(count);
        code_backlog.push_back(value);
    endfunction

    function automatic void queue_end_marker();
        code_backlog.push_back(ESC_BYTE);
        code_backlog.push_back(ESC_BYTE);
        code_backlog.push_back(8'd0);
    endfunction

    initial begin
        int          pick;
        int          ntok;
        logic [15:0] start_val;
        logic [15:0] size_val;

        restart_decode();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset values: literals, lone escape, long run, end marker
        idling_on = 1'b1;
        settings_used++;
        code_backlog.push_back(8'h00);
        code_backlog.push_back(8'hFF);
        queue_lone_esc(8'h5A);
        queue_run(8'hFF, ESC_BYTE);
        queue_run(8'h01, 8'h00);
        queue_end_marker();
        code_backlog.push_back(8'h7E);
        wait_for_idle();

        // clamped run wrapping the address, then an ignored byte
        write_reg(CFG_START_ADDR, 16'hFFFE);
        write_reg(CFG_BLOCK_SIZE, 16'd3);
        settings_used++;
        code_backlog.push_back(8'h11);
        queue_run(8'h05, 8'hAA);
        code_backlog.push_back(8'h22);
        wait_for_idle();

        // lone escape fills the last byte, follower dropped
        write_reg(CFG_START_ADDR, 16'h0000);
        write_reg(CFG_BLOCK_SIZE, 16'd1);
        settings_used++;
        queue_lone_esc(8'h33);
        wait_for_idle();

        write_reg(CFG_START_ADDR, 16'hFFFF);
        write_reg(CFG_BLOCK_SIZE, 16'hFFFF);
        settings_used++;
        queue_end_marker();
        code_backlog.push_back(8'h44);
        wait_for_idle();

        while (sent_bytes < ITEM_TARGET) begin
            idling_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 3))
                0: start_val = 16'h0000;
                1: start_val = 16'hFFFF;
                2: start_val = 16'($urandom_range(16'hFF00, 16'hFFFF));
                default: start_val = 16'($urandom_range(0, 16'hFFFF));
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 2)
                size_val = 16'd1;
            else if (pick == 2)
                size_val = 16'hFFFF;
            else if (pick < 8)
                size_val = 16'($urandom_range(2, 16));
            else if (pick < 16)
                size_val = 16'($urandom_range(17, 600));
            else
                size_val = 16'($urandom_range(601, 4000));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_START_ADDR, start_val);
                1: write_reg(CFG_BLOCK_SIZE, size_val);
                2: begin
                    write_reg(CFG_START_ADDR, start_val);
                    write_reg(CFG_BLOCK_SIZE, size_val);
                end
                default: begin
                    write_reg(CFG_BLOCK_SIZE, size_val);
                    write_reg(CFG_START_ADDR, start_val);
                end
            endcase
            settings_used++;

            ntok = $urandom_range(8, 60);
            repeat (ntok) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    code_backlog.push_back(plain_byte());
                else if (pick < 60)
                    queue_lone_esc(plain_byte());
                else if (pick < 85)
                    queue_run(8'(($urandom_range(0, 2) != 0) ? $urandom_range(1, 20)
                                                             : $urandom_range(1, 255)),
                              8'($urandom_range(0, 255)));
                else if (pick < 88)
                    queue_end_marker();
                else
                    code_backlog.push_back(8'($urandom_range(0, 255)));
            end
            wait_for_idle();
            if (sent_bytes >= ITEM_TARGET - QUIET_TAIL)
                quiet = 1'b1;
        end

        wait_for_idle();
        if (expected_runs.size() != 0)
            report_mismatch("runs still outstanding", 32'(expected_runs.size()), 32'd0);
        $display("Covered %0d input bytes (%0d decoded), %0d runs, %0d completed blocks",
                 sent_bytes, live_bytes, runs_seen, blocks_done);
        $display("over %0d block settings with %0d register writes", settings_used, reg_writes);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/erle_pkg.sv
rtl/erle_decode.sv
rtl/escape_rle_block_decoder.sv
dv/testbench.sv
